### hw/rtl/sis_pkg.sv
// Package: constants and types for the sorted interval set.
package sis_pkg;
    localparam int MAX_INTERVALS = 16;
    localparam int COORD_BITS    = 32;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int ENT_W         = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;
endpackage

### hw/rtl/sorted_interval_set_top.sv
// Top level: sorted interval set with ping-pong table memories and scan sequencer.
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_      | in  | range_start[31:0], range_end[63:32]       | action[1:0]
//  m_      | out | covered[0], status[2:1]                   | -
//
// Add and remove scan the stored entries twice (count, then rewrite), one entry a cycle
// through the single read port of the active table; in the rewrite the read pauses when
// an entry takes a second write slot. A query scans once. Empty ranges and unknown
// actions skip the scan and go straight to the result.
// Rewrites go into the other table, which then becomes active.
// Reset clears the count and the table select; no clearing pass. A stalled result
// holds in the output register while the next request is already taken.
module sorted_interval_set_top
    import sis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // range_start, range_end
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // covered, status, zero pad
);
    typedef enum logic [2:0] {
        S_IDLE, S_CNT, S_DEC, S_WR, S_DONE
    } state_t;

    state_t   state_reg;
    action_t  act_reg;
    coord_t   lo_reg, hi_reg;
    cnt_t     count_reg, k_reg, i_reg, tally_reg;
    logic     bank_reg, placed_reg, cov_reg, pend_reg;
    logic     rv_reg;
    status_t  st_reg;
    logic     m_valid_reg;
    logic [7:0] m_data_reg;
    // second write for a remove split or an add insertion
    logic     w2_reg;
    logic [ENT_W-1:0] w2_data_reg;

    logic [ENT_W-1:0] rd0, rd1, rd;
    logic             we0, we1, we;
    idx_t             waddr;
    logic [ENT_W-1:0] wdata;
    idx_t             raddr;

    sis_ram #(.WIDTH(ENT_W), .DEPTH(MAX_INTERVALS)) u_ram0 (
        .aclk(aclk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0));
    sis_ram #(.WIDTH(ENT_W), .DEPTH(MAX_INTERVALS)) u_ram1 (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1));

    assign rd  = bank_reg ? rd1 : rd0;
    assign we0 = we && bank_reg;
    assign we1 = we && !bank_reg;
    assign raddr = i_reg[IDX_W-1:0];

    coord_t s_e, t_e;
    assign s_e = rd[COORD_BITS-1:0];
    assign t_e = rd[ENT_W-1:COORD_BITS];

    logic   out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !pend_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // write-phase decisions on the entry read last cycle
    logic             keep, w_a, w_b;
    logic [ENT_W-1:0] d_a, d_b;
    always_comb begin
        keep = 1'b0; w_a = 1'b0; w_b = 1'b0;
        d_a = rd; d_b = rd;
        if (act_reg == ACT_ADD) begin
            if (s_e > hi_reg) begin
                if (!placed_reg) begin
                    w_a = 1'b1; d_a = {hi_reg, lo_reg};
                    w_b = 1'b1; d_b = rd;
                end else begin
                    w_a = 1'b1; d_a = rd;
                end
            end else if (t_e < lo_reg) begin
                w_a = 1'b1; d_a = rd;
            end else begin
                keep = 1'b1;
            end
        end else begin
            if (t_e <= lo_reg || s_e >= hi_reg) begin
                w_a = 1'b1; d_a = rd;
            end else if (s_e < lo_reg) begin
                w_a = 1'b1; d_a = {lo_reg, s_e};
                if (t_e > hi_reg) begin
                    w_b = 1'b1; d_b = {t_e, hi_reg};
                end
            end else if (t_e > hi_reg) begin
                w_a = 1'b1; d_a = {t_e, hi_reg};
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = k_reg[IDX_W-1:0];
        wdata = d_a;
        if (state_reg == S_WR && w2_reg) begin
            we = 1'b1; wdata = w2_data_reg;
        end else if (state_reg == S_WR && rv_reg && w_a) begin
            we = 1'b1;
        end else if (state_reg == S_DONE && act_reg == ACT_ADD && !placed_reg) begin
            we = 1'b1; wdata = {hi_reg, lo_reg};
        end
    end

    coord_t in_lo, in_hi;
    assign in_lo = s_tdata[COORD_BITS-1:0];
    assign in_hi = s_tdata[32+COORD_BITS-1:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            rv_reg      <= 1'b0;
            w2_reg      <= 1'b0;
        end else begin
            if (pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {5'd0, st_reg, cov_reg};
                pend_reg    <= 1'b0;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg    <= action_t'(s_tuser);
                        lo_reg     <= in_lo;
                        hi_reg     <= in_hi;
                        i_reg      <= '0;
                        k_reg      <= '0;
                        tally_reg  <= '0;
                        placed_reg <= 1'b0;
                        cov_reg    <= 1'b0;
                        st_reg     <= (in_lo >= in_hi) ? ST_EMPTY : ST_OK;
                        rv_reg     <= 1'b0;
                        if (in_lo >= in_hi) begin
                            pend_reg <= 1'b1;
                        end else if (action_t'(s_tuser) == ACT_NONE) begin
                            pend_reg <= 1'b1;
                        end else begin
                            state_reg <= S_CNT;
                        end
                    end
                end
                S_CNT: begin
                    // read issued at i_reg; data of i_reg-1 valid when rv_reg
                    if (rv_reg) begin
                        if (act_reg == ACT_ADD && !(s_e > hi_reg || t_e < lo_reg)) begin
                            tally_reg <= tally_reg + 1'b1;
                        end
                        if (act_reg == ACT_REMOVE && s_e < lo_reg && t_e > hi_reg) begin
                            tally_reg <= tally_reg + 1'b1;
                        end
                        if (act_reg == ACT_QUERY && s_e <= lo_reg && t_e >= hi_reg) begin
                            cov_reg <= 1'b1;
                        end
                    end
                    if (i_reg < count_reg) begin
                        i_reg  <= i_reg + 1'b1;
                        rv_reg <= 1'b1;
                    end else begin
                        rv_reg    <= 1'b0;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    i_reg <= '0;
                    if (act_reg == ACT_QUERY) begin
                        pend_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if ((act_reg == ACT_ADD &&
                                  {1'b0, count_reg} - {1'b0, tally_reg} + 1'b1 >
                                  (CNT_W+1)'(MAX_INTERVALS)) ||
                                 (act_reg == ACT_REMOVE &&
                                  {1'b0, count_reg} + {1'b0, tally_reg} >
                                  (CNT_W+1)'(MAX_INTERVALS))) begin
                        st_reg    <= ST_FULL;
                        pend_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_WR;
                    end
                end
                S_WR: begin
                    if (w2_reg) begin
                        w2_reg <= 1'b0;
                        k_reg  <= k_reg + 1'b1;
                        if (i_reg < count_reg) begin
                            i_reg  <= i_reg + 1'b1;
                            rv_reg <= 1'b1;
                        end else begin
                            rv_reg <= 1'b0;
                        end
                    end else begin
                        if (rv_reg) begin
                            if (act_reg == ACT_ADD && keep) begin
                                if (s_e < lo_reg) lo_reg <= s_e;
                                if (t_e > hi_reg) hi_reg <= t_e;
                            end
                            if (act_reg == ACT_ADD && s_e > hi_reg && !placed_reg) begin
                                placed_reg <= 1'b1;
                            end
                            if (w_a) begin
                                k_reg <= k_reg + 1'b1;
                            end
                            if (w_b) begin
                                w2_reg      <= 1'b1;
                                w2_data_reg <= d_b;
                            end
                        end
                        if (rv_reg && w_b) begin
                            rv_reg <= 1'b0;
                        end else if (i_reg < count_reg) begin
                            i_reg  <= i_reg + 1'b1;
                            rv_reg <= 1'b1;
                        end else begin
                            rv_reg    <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    count_reg <= (act_reg == ACT_ADD && !placed_reg) ? k_reg + 1'b1 : k_reg;
                    bank_reg  <= !bank_reg;
                    pend_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/sis_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module sis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/sis_checker.sv
// Checker: port-level properties of the sorted interval set, bound to the top level.
module sis_checker
    import sis_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
        else $error("bad status code");
    a_cov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_OK)
        else $error("covered with error status");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[31:0] >= s_tdata[63:32] && !(m_tvalid && !m_tready)
        |=> ##1 m_tvalid && m_tdata[2:1] == ST_EMPTY)
        else $error("empty range not flagged");
endmodule

bind sorted_interval_set_top sis_checker u_sis_checker (.*);
